>>> rtl/core/fbla_pkg.sv
// ----------------------------------------------------------------------------
// fbla_pkg
// shared types and codes for the free block list allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fbla_pkg;

   localparam int BLOCK_W = 24;
   localparam int CMP_W   = BLOCK_W + 1;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [CMP_W-1:0]   cmp_type;
   typedef logic [2:0]         status_type;
   typedef logic [1:0]         op_type;

   // request opcodes
   localparam op_type OP_FREE   = 2'd0;
   localparam op_type OP_ALLOC  = 2'd1;
   localparam op_type OP_REFILL = 2'd2;

   // result status codes
   localparam status_type ST_OK     = 3'd0;
   localparam status_type ST_RANGE  = 3'd1;
   localparam status_type ST_NOBLK  = 3'd2;
   localparam status_type ST_REFILL = 3'd3;
   localparam status_type ST_WRONG  = 3'd4;

   // csr register indexes
   localparam logic [7:0] REG_INODE_BLOCKS = 8'd0;
   localparam logic [7:0] REG_TOTAL_BLOCKS = 8'd1;

endpackage

`default_nettype wire

>>> rtl/core/fbla_cmp.sv
// ----------------------------------------------------------------------------
// fbla_cmp
// shared unsigned less-than unit, one subtract per use
// ----------------------------------------------------------------------------
`default_nettype none

module fbla_cmp (
   input  fbla_pkg::cmp_type a,
   input  fbla_pkg::cmp_type b,
   output logic              lt
);
   import fbla_pkg::*;

   logic [CMP_W:0] diff;

   // borrow out of a - b marks a < b
   assign diff = {1'b0, a} - {1'b0, b};
   assign lt   = diff[CMP_W];

endmodule

`default_nettype wire

>>> rtl/core/fbla_store.sv
// ----------------------------------------------------------------------------
// fbla_store
// free list entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fbla_store #(
   parameter int DEPTH = 63,
   parameter int IDX_W = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  fbla_pkg::block_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output fbla_pkg::block_type rd_data
);
   import fbla_pkg::*;

   block_type        mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   block_type        rd_q_ff;
   logic             rd_vld_ff;

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff   <= mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

>>> rtl/core/free_block_list_allocator.sv
// ----------------------------------------------------------------------------
// free_block_list_allocator
// stack of free block numbers with spill on overflow and refill on underflow
// ----------------------------------------------------------------------------
// A request word is taken only while the sequencer is idle; it then owns the
// block until its last result is loaded into the output register. One shared
// 25 bit comparator does the range check on a free (two passes, lower then
// upper bound) and the count saturation on a refill, and the entry memory has
// a single registered read port. A free runs the lower check, the upper check
// and the push, which on an empty list first restores the sentinel. A free
// into a full list sends the count word and then LIST_DEPTH entries, one word
// per cycle while the output drains. Entries carry valid bits cleared by
// reset, so no clearing pass is needed and the block is ready right after
// reset. Status values: 0 ok, 1 out of range, 2 no free block, 3 refill
// needed, 4 wrong op now.
`default_nettype none

module free_block_list_allocator #(
   parameter int LIST_DEPTH = 63
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] block_word
   input  logic [1:0]  req_tuser,   // [1:0] op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [23:0] value, [47:24] target_block, [50:48] status
   output logic [0:0]  rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [23:0] csr_data
);
   import fbla_pkg::*;

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHK_LO = 3'd1;
   localparam logic [2:0] S_CHK_HI = 3'd2;
   localparam logic [2:0] S_PUSH   = 3'd3;
   localparam logic [2:0] S_SPILL  = 3'd4;
   localparam logic [2:0] S_POP    = 3'd5;
   localparam logic [2:0] S_REFILL = 3'd6;
   localparam logic [2:0] S_RESP   = 3'd7;

   // control state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             refill_ff, refill_in;
   logic [IDX_W-1:0] spill_idx_ff, spill_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   block_type        inode_ff, total_ff;

   // per-word payload
   block_type        word_ff, word_in;
   logic             lo_ok_ff, lo_ok_in;
   status_type       rstat_ff, rstat_in;
   logic             o_kind_ff, o_kind_in;
   block_type        o_value_ff, o_value_in;
   block_type        o_target_ff, o_target_in;
   status_type       o_status_ff, o_status_in;
   logic             o_last_ff, o_last_in;

   // memory and comparator hookup
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   block_type        wr_data, rd_data;
   cmp_type          cmp_a, cmp_b;
   logic             cmp_lt;

   // sequencer helpers
   logic             req_accept;
   logic             out_free;
   logic [CNT_W-1:0] cnt_m1, pos_p1, refill_cnt;
   logic             spill_end;
   logic             emit, e_kind, e_last;
   block_type        e_value, e_target;
   status_type       e_status;

   fbla_cmp u_cmp (
      .a  (cmp_a),
      .b  (cmp_b),
      .lt (cmp_lt)
   );

   fbla_store #(
      .DEPTH (LIST_DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // output register frees up when empty or being taken this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cnt_m1     = count_ff - CNT_W'(1);
   assign pos_p1     = pos_ff + CNT_W'(1);
   assign spill_end  = (spill_idx_ff == IDX_W'(LIST_DEPTH - 1));
   // refill count clipped to the list depth
   assign refill_cnt = cmp_lt ? CNT_W'(LIST_DEPTH) : word_ff[CNT_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      refill_in    = refill_ff;
      spill_idx_in = spill_idx_ff;
      word_in      = word_ff;
      lo_ok_in     = lo_ok_ff;
      rstat_in     = rstat_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      cmp_a        = '0;
      cmp_b        = '0;
      emit         = 1'b0;
      e_kind       = 1'b0;
      e_value      = '0;
      e_target     = '0;
      e_status     = ST_OK;
      e_last       = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               word_in = req_tdata;
               if (req_tuser == OP_FREE && !refill_ff) begin
                  state_in = S_CHK_LO;
               end else if (req_tuser == OP_ALLOC && !refill_ff) begin
                  if (count_ff == '0) begin
                     rstat_in = ST_NOBLK;
                     state_in = S_RESP;
                  end else begin
                     // fetch top of stack
                     rd_en    = 1'b1;
                     rd_addr  = cnt_m1[IDX_W-1:0];
                     state_in = S_POP;
                  end
               end else if (req_tuser == OP_REFILL && refill_ff) begin
                  state_in = S_REFILL;
               end else begin
                  rstat_in = ST_WRONG;
                  state_in = S_RESP;
               end
            end
         end

         // lower bound: inode_blocks + 1 < word
         S_CHK_LO: begin
            cmp_a    = {1'b0, inode_ff} + CMP_W'(1);
            cmp_b    = {1'b0, word_ff};
            lo_ok_in = cmp_lt;
            state_in = S_CHK_HI;
         end

         // upper bound: word < total_blocks
         S_CHK_HI: begin
            cmp_a = {1'b0, word_ff};
            cmp_b = {1'b0, total_ff};
            if (lo_ok_ff && cmp_lt) begin
               state_in = S_PUSH;
            end else begin
               rstat_in = ST_RANGE;
               state_in = S_RESP;
            end
         end

         S_PUSH: begin
            if (count_ff == '0) begin
               // empty list gets its zero sentinel back first
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = '0;
               count_in = CNT_W'(1);
            end else if (count_ff >= CNT_W'(LIST_DEPTH)) begin
               if (out_free) begin
                  // spill run opens with the count word
                  emit         = 1'b1;
                  e_kind       = 1'b1;
                  e_value      = BLOCK_W'(LIST_DEPTH);
                  e_target     = word_ff;
                  e_last       = 1'b0;
                  rd_en        = 1'b1;
                  rd_addr      = '0;
                  spill_idx_in = '0;
                  state_in     = S_SPILL;
               end
            end else if (out_free) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IDX_W-1:0];
               wr_data  = word_ff;
               count_in = count_ff + CNT_W'(1);
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end

         // one entry per cycle while the output drains, next read issued as the current one leaves
         S_SPILL: begin
            if (out_free) begin
               emit     = 1'b1;
               e_kind   = 1'b1;
               e_value  = rd_data;
               e_target = word_ff;
               e_last   = spill_end;
               if (spill_end) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = word_ff;
                  count_in = CNT_W'(1);
                  state_in = S_IDLE;
               end else begin
                  rd_en        = 1'b1;
                  rd_addr      = spill_idx_ff + IDX_W'(1);
                  spill_idx_in = spill_idx_ff + IDX_W'(1);
               end
            end
         end

         S_POP: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (rd_data == '0) begin
                  // sentinel: volume full, sentinel stays
                  e_status = ST_NOBLK;
               end else begin
                  count_in = cnt_m1;
                  e_value  = rd_data;
                  if (cnt_m1 == '0) begin
                     refill_in = 1'b1;
                     pos_in    = '0;
                     e_target  = rd_data;
                     e_status  = ST_REFILL;
                  end
               end
            end
         end

         S_REFILL: begin
            cmp_a = CMP_W'(LIST_DEPTH);
            cmp_b = {1'b0, word_ff};
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (count_ff == '0) begin
                  // count word
                  pos_in = '0;
                  if (refill_cnt == '0) begin
                     refill_in = 1'b0;
                  end else begin
                     count_in = refill_cnt;
                  end
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = pos_ff[IDX_W-1:0];
                  wr_data = word_ff;
                  pos_in  = pos_p1;
                  if (pos_p1 >= count_ff) begin
                     refill_in = 1'b0;
                     pos_in    = '0;
                  end
               end
            end
         end

         S_RESP: begin
            if (out_free) begin
               emit     = 1'b1;
               e_status = rstat_ff;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // output register load
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      o_kind_in    = o_kind_ff;
      o_value_in   = o_value_ff;
      o_target_in  = o_target_ff;
      o_status_in  = o_status_ff;
      o_last_in    = o_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         o_kind_in    = e_kind;
         o_value_in   = e_value;
         o_target_in  = e_target;
         o_status_in  = e_status;
         o_last_in    = e_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(1);
         pos_ff       <= '0;
         refill_ff    <= 1'b0;
         spill_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         inode_ff     <= '0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         refill_ff    <= refill_in;
         spill_idx_ff <= spill_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         // register writes, other indexes ignored
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_INODE_BLOCKS) begin
               inode_ff <= csr_data;
            end else if (csr_index == REG_TOTAL_BLOCKS) begin
               total_ff <= csr_data;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      lo_ok_ff    <= lo_ok_in;
      rstat_ff    <= rstat_in;
      o_kind_ff   <= o_kind_in;
      o_value_ff  <= o_value_in;
      o_target_ff <= o_target_in;
      o_status_ff <= o_status_in;
      o_last_ff   <= o_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, o_status_ff, o_target_ff, o_value_ff};
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;

endmodule

`default_nettype wire

>>> rtl/core/fbla_checker.sv
// ----------------------------------------------------------------------------
// fbla_checker
// port-level checks for the free block list allocator
// ----------------------------------------------------------------------------
`default_nettype none

module fbla_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import fbla_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // one word at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous word in progress");

   // spill words always carry ok status
   a_spill_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[50:48] == ST_OK)
      else $error("spill word with non-ok status");

   // answers are single-word runs
   a_answer_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("answer word without last");

   // status stays within defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[50:48] == ST_OK || rsp_tdata[50:48] == ST_RANGE
         || rsp_tdata[50:48] == ST_NOBLK || rsp_tdata[50:48] == ST_REFILL
         || rsp_tdata[50:48] == ST_WRONG)
      else $error("undefined status code");

endmodule

bind free_block_list_allocator fbla_checker u_fbla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
